// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the deque RTL.
// Every macro uses the clock clk and the active-low reset arst_n of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while the block is out of reset.
`define CDQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Checks that a consequence holds in the cycle after its trigger.
`define CDQ_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/cdq_pkg.sv =====
// Shared types and constants for the circular deque unit.
// It has no dependencies. The top level and the entry store import it.
package cdq_pkg;

	localparam int VALUE_W    = 32;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int OCC_W      = 5;
	localparam int WIDE_W     = 64;
	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_HEAD = 2'd0,
		CMD_PUSH_TAIL = 2'd1,
		CMD_POP_HEAD  = 2'd2,
		CMD_POP_TAIL  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

endpackage

// ===== hdl/circular_deque_unit.sv =====
// Circular deque unit: a double-ended queue of DEPTH entries held in a ring memory.
// It depends on cdq_pkg, on cdq_ram and on assert_macros.svh.
//
// Usage:
// Each input beat on the s_ side carries a command in s_tuser and a push value in s_tdata.
// The commands are push at head, push at tail, pop head and pop tail.
// Each command gives exactly one result beat on the m_ side. That beat carries the popped
// value and the occupancy after the command in m_tdata, and the status in m_tuser.
// A push is answered on the cycle after it is accepted.
// A pop reads the entry memory, whose read port is registered, so its result passes through
// the read register of the entry memory and then the output register.
// Pushes therefore sustain one beat per cycle while the receiver does not stall. After a pop,
// no new beat is taken until the single registered read port of the entry memory has read it.
// A push into a full deque is rejected with a full status. A pop from an empty deque returns
// an empty status and a zero value. Neither changes the state.
// Reset clears the head and tail pointers and the entry count. The memory contents are left
// as they are.
// The result is held in an output register. While the receiver stalls, one finished
// result waits there and s_tready drops until that result is taken.
`include "assert_macros.svh"

module circular_deque_unit
	import cdq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] push_value
	input  logic [CMD_W-1:0]       s_tuser,   // [1:0] command
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] pop_value, [36:32] occupancy, [39:37] zero
	output logic [STATUS_W-1:0]    m_tuser    // [1:0] status
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	state_t state_q, state_d;
	logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] head_next, head_prev, tail_next, tail_prev;

	logic m_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	status_t out_status_q;
	logic [OCC_W-1:0] out_occ_q;

	logic accept;
	cmd_t cmd;
	status_t status_d;
	logic is_full, is_empty;
	logic wr_en, rd_en;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	logic [WIDE_W-1:0] push_wide;
	logic [DATA_WIDTH-1:0] wr_data, rd_data;
	logic signed [DATA_WIDTH-1:0] rd_signed;
	logic [WIDE_W-1:0] pop_wide;

	// A new beat is taken only when the read path is free and the output register will be empty.
	assign s_tready = (state_q == ST_IDLE) && (!m_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign cmd      = cmd_t'(s_tuser);

	assign is_full  = (count_q == FULL_CNT);
	assign is_empty = (count_q == '0);

	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign head_prev = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;

	// A push keeps the low DATA_WIDTH bits of the sign-extended value.
	assign push_wide = WIDE_W'(signed'(s_tdata[VALUE_W-1:0]));
	assign wr_data   = push_wide[DATA_WIDTH-1:0];

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		status_d = STS_OK;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		wr_addr  = head_prev;
		rd_addr  = head_q;
		state_d  = state_q;
		if (state_q == ST_READ) begin
			state_d = ST_IDLE;
		end
		if (accept) begin
			unique case (cmd)
				CMD_PUSH_HEAD: begin
					if (is_full) begin
						status_d = STS_FULL;
					end else begin
						wr_en   = 1'b1;
						wr_addr = head_prev;
						head_d  = head_prev;
						count_d = count_q + 1'b1;
					end
				end
				CMD_PUSH_TAIL: begin
					if (is_full) begin
						status_d = STS_FULL;
					end else begin
						wr_en   = 1'b1;
						wr_addr = tail_q;
						tail_d  = tail_next;
						count_d = count_q + 1'b1;
					end
				end
				CMD_POP_HEAD: begin
					if (is_empty) begin
						status_d = STS_EMPTY;
					end else begin
						rd_en   = 1'b1;
						rd_addr = head_q;
						head_d  = head_next;
						count_d = count_q - 1'b1;
						state_d = ST_READ;
					end
				end
				CMD_POP_TAIL: begin
					if (is_empty) begin
						status_d = STS_EMPTY;
					end else begin
						rd_en   = 1'b1;
						rd_addr = tail_prev;
						tail_d  = tail_prev;
						count_d = count_q - 1'b1;
						state_d = ST_READ;
					end
				end
				default: begin
					status_d = STS_OK;
				end
			endcase
		end
	end

	cdq_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// A popped entry is sign-extended from DATA_WIDTH bits, then cut to the field width.
	assign rd_signed = rd_data;
	assign pop_wide  = WIDE_W'(rd_signed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if ((accept && state_d != ST_READ) || state_q == ST_READ) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			out_value_q  <= pop_wide[VALUE_W-1:0];
			out_status_q <= STS_OK;
			out_occ_q    <= OCC_W'(count_q);
		end else if (accept) begin
			out_value_q  <= '0;
			out_status_q <= status_d;
			out_occ_q    <= OCC_W'(count_d);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - OCC_W - VALUE_W)'(0), out_occ_q, out_value_q};
	assign m_tuser  = out_status_q;

	`CDQ_ASSERT(a_count_bound, count_q <= FULL_CNT, "entry count exceeds the capacity")
	`CDQ_ASSERT(a_read_slot_free, (state_q != ST_READ) || !m_valid_q,
		"output register busy while a popped entry is being read")
	`CDQ_ASSERT_NEXT(a_pop_reads, accept && rd_en, state_q == ST_READ && m_valid_q == 1'b0,
		"a pop did not move to the read state")
	`CDQ_ASSERT(a_count_step, (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1)
		|| (count_q == $past(count_q) - 1'b1), "entry count moved by more than one")

endmodule

// ===== hdl/cdq_ram.sv =====
// Entry store of the circular deque: one write port and one registered read port.
// It depends on cdq_pkg only for the house conventions. Contents are undefined until written.
module cdq_ram
	import cdq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  logic [DATA_WIDTH-1:0]        wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(DEPTH)-1:0]     rd_addr,
	output logic [DATA_WIDTH-1:0]        rd_data
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
